[rtl/scr_pkg.sv]
// ----------------------------------------------------------------------------
// Supercover ray cells package
// Shared types and constants for the supercover DDA ray walker.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int FIELD_WIDTH = 4;
  localparam int COORD_WIDTH = 5;
  localparam int CNT_WIDTH   = 10;

  typedef logic signed [FIELD_WIDTH-1:0] field_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [CNT_WIDTH-1:0]          cnt_t;

  typedef struct packed {
    field_t row_start;
    field_t col_start;
    field_t row_end;
    field_t col_end;
  } in_item_t;

  typedef struct packed {
    field_t cell_row;
    field_t cell_col;
    logic   last_cell;
  } out_item_t;

  typedef struct packed {
    field_t row;
    field_t col;
  } cell_t;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_STEP      = 5'b00010,
    ST_CORN_COL  = 5'b00100,
    ST_CORN_DIAG = 5'b01000,
    ST_FLUSH     = 5'b10000
  } state_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
    cnt_t   cnt_row;
    cnt_t   cnt_col;
    coord_t step_row;
    coord_t step_col;
    cnt_t   inc_row;
    cnt_t   inc_col;
    coord_t end_row;
    coord_t end_col;
  } walk_t;

  typedef struct packed {
    walk_t  nxt;
    cell_t  pos;
    logic   emit;
    logic   done;
    state_t next_state;
  } step_res_t;

  typedef struct packed {
    logic push_ready;
    logic flush_ready;
    logic pend_valid;
  } out_status_t;

endpackage

[rtl/supercover_ray_cells_unit.sv]
// ----------------------------------------------------------------------------
// Supercover ray cells unit
// Walks a supercover DDA ray and emits every cell strictly between the ends.
// ----------------------------------------------------------------------------
// Output path: each cell waits in the pending register of the output stage until the
// next cell or the end-of-ray flush moves it into the output register.
// Flow: a ray is walked one sub-step per cycle while the output is not stalled (each
// emitted cell plus the final step onto the end cell), then flushed; the flush also
// waits on a free output, no new ray is taken until idle, and equal endpoints start no walk.
// Reset: synchronous, active low; the unit comes up idle with no output.
module supercover_ray_cells_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scr_pkg::out_item_t  out_data
);
  import scr_pkg::*;

  state_t      state_r;
  state_t      state_nxt;
  walk_t       walk_r;
  walk_t       walk_nxt;
  step_res_t   res;
  out_status_t st;
  logic        in_fire;
  logic        walking;
  logic        advance;
  logic        push;
  logic        flush;
  logic        same_ends;
  coord_t      r0;
  coord_t      c0;
  coord_t      r1;
  coord_t      c1;
  coord_t      dr;
  coord_t      dc;
  coord_t      adr;
  coord_t      adc;
  cnt_t        adr_cnt;
  cnt_t        adc_cnt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign r0  = COORD_WIDTH'(in_data.row_start);
  assign c0  = COORD_WIDTH'(in_data.col_start);
  assign r1  = COORD_WIDTH'(in_data.row_end);
  assign c1  = COORD_WIDTH'(in_data.col_end);
  assign dr  = r1 - r0;
  assign dc  = c1 - c0;
  assign adr = dr[COORD_WIDTH-1] ? -dr : dr;
  assign adc = dc[COORD_WIDTH-1] ? -dc : dc;
  assign adr_cnt   = {{(CNT_WIDTH-COORD_WIDTH){1'b0}}, adr};
  assign adc_cnt   = {{(CNT_WIDTH-COORD_WIDTH){1'b0}}, adc};
  assign same_ends = (dr == '0) && (dc == '0);

  scr_step_unit u_step (
    .state (state_r),
    .walk  (walk_r),
    .res   (res)
  );

  assign walking = (state_r == ST_STEP) || (state_r == ST_CORN_COL) ||
                   (state_r == ST_CORN_DIAG);
  assign advance = walking && (!res.emit || st.push_ready);
  assign push    = advance && res.emit;
  assign flush   = (state_r == ST_FLUSH);

  scr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cell (res.pos),
    .flush     (flush),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (st)
  );

  always_comb begin
    state_nxt = state_r;
    walk_nxt  = walk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !same_ends) begin
          walk_nxt.row      = r0;
          walk_nxt.col      = c0;
          walk_nxt.cnt_row  = adc_cnt;
          walk_nxt.cnt_col  = adr_cnt;
          walk_nxt.step_row = dr[COORD_WIDTH-1] ? '1 :
                              ((dr != '0) ? COORD_WIDTH'(1) : '0);
          walk_nxt.step_col = dc[COORD_WIDTH-1] ? '1 :
                              ((dc != '0) ? COORD_WIDTH'(1) : '0);
          walk_nxt.inc_row  = adc_cnt << 1;
          walk_nxt.inc_col  = adr_cnt << 1;
          walk_nxt.end_row  = r1;
          walk_nxt.end_col  = c1;
          state_nxt         = ST_STEP;
        end
      end
      ST_STEP, ST_CORN_COL, ST_CORN_DIAG: begin
        if (advance) begin
          walk_nxt  = res.nxt;
          state_nxt = res.done ? ST_FLUSH : res.next_state;
        end
      end
      ST_FLUSH: begin
        if (st.flush_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    walk_r <= walk_nxt;
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !st.pend_valid)
    else $error("pending cell left over while accepting a new ray");

  a_corner_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORN_COL) |-> (walk_r.cnt_row == walk_r.cnt_col))
    else $error("corner phase entered without equal crossing counters");

  a_same_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && same_ends) |=> (state_r == ST_IDLE))
    else $error("ray with equal endpoints started a walk");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && !out_stall) |=> (state_r == ST_IDLE))
    else $error("flush did not complete with a free output");

endmodule

[rtl/scr_step_unit.sv]
// ----------------------------------------------------------------------------
// Supercover ray step unit
// Shared compare and add unit that performs one walk sub-step per cycle when the walker advances.
// ----------------------------------------------------------------------------
module scr_step_unit (
  input  scr_pkg::state_t    state,
  input  scr_pkg::walk_t     walk,
  output scr_pkg::step_res_t res
);
  import scr_pkg::*;

  coord_t cand_row;
  coord_t cand_col;
  logic   at_end;
  logic   corner;

  always_comb begin
    res            = '0;
    res.nxt        = walk;
    res.next_state = state;
    cand_row       = walk.row;
    cand_col       = walk.col;
    at_end         = 1'b0;
    corner         = 1'b0;
    unique case (state)
      ST_STEP: begin
        if (walk.cnt_row < walk.cnt_col) begin
          res.nxt.row     = walk.row + walk.step_row;
          res.nxt.cnt_row = walk.cnt_row + walk.inc_row;
        end else if (walk.cnt_col < walk.cnt_row) begin
          res.nxt.col     = walk.col + walk.step_col;
          res.nxt.cnt_col = walk.cnt_col + walk.inc_col;
        end else begin
          corner = 1'b1;
        end
        if (corner) begin
          cand_row       = walk.row + walk.step_row;
          cand_col       = walk.col;
          at_end         = (cand_row == walk.end_row) && (cand_col == walk.end_col);
          res.emit       = !at_end;
          res.next_state = ST_CORN_COL;
        end else begin
          cand_row       = res.nxt.row;
          cand_col       = res.nxt.col;
          at_end         = (cand_row == walk.end_row) && (cand_col == walk.end_col);
          res.done       = at_end;
          res.emit       = !at_end;
          res.next_state = ST_STEP;
        end
      end
      ST_CORN_COL: begin
        cand_row       = walk.row;
        cand_col       = walk.col + walk.step_col;
        at_end         = (cand_row == walk.end_row) && (cand_col == walk.end_col);
        res.emit       = !at_end;
        res.next_state = ST_CORN_DIAG;
      end
      ST_CORN_DIAG: begin
        res.nxt.row     = walk.row + walk.step_row;
        res.nxt.col     = walk.col + walk.step_col;
        res.nxt.cnt_row = walk.cnt_row + walk.inc_row;
        res.nxt.cnt_col = walk.cnt_col + walk.inc_col;
        cand_row        = res.nxt.row;
        cand_col        = res.nxt.col;
        at_end          = (cand_row == walk.end_row) && (cand_col == walk.end_col);
        res.done        = at_end;
        res.emit        = !at_end;
        res.next_state  = ST_STEP;
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
    res.pos.row = cand_row[FIELD_WIDTH-1:0];
    res.pos.col = cand_col[FIELD_WIDTH-1:0];
  end

endmodule

[rtl/scr_out_stage.sv]
// ----------------------------------------------------------------------------
// Supercover ray output stage
// Holds one pending cell so that the final cell of a ray can be flagged.
// ----------------------------------------------------------------------------
module scr_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scr_pkg::cell_t      push_cell,
  input  logic                flush,
  output logic                out_valid,
  input  logic                out_stall,
  output scr_pkg::out_item_t  out_data,
  output scr_pkg::out_status_t status
);
  import scr_pkg::*;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      pend_valid_r;
  logic      pend_valid_nxt;
  cell_t     pend_r;
  cell_t     pend_nxt;
  logic      out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    if (push) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{cell_row: pend_r.row, cell_col: pend_r.col, last_cell: 1'b0};
      end
      pend_nxt       = push_cell;
      pend_valid_nxt = 1'b1;
    end else if (flush && pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '{cell_row: pend_r.row, cell_col: pend_r.col, last_cell: 1'b1};
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign status.push_ready  = !pend_valid_r || out_free;
  assign status.flush_ready = !pend_valid_r || out_free;
  assign status.pend_valid  = pend_valid_r;

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Supercover ray cells testbench
// Drives rays into the walker and checks each emitted cell, in order, against
// a local supercover DDA walk. Both sides idle at random, and one phase holds
// off the output long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import scr_pkg::*;

  localparam int MAX_RAY_CELLS = 44;
  localparam int RANDOM_RAYS   = 120;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  logic      jitter;
  logic      hold_sink;
  bit        failed;
  out_item_t expected_cells[$];
  out_item_t want;

  supercover_ray_cells_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  function automatic in_item_t make_ray(input int r0, input int c0, input int r1, input int c1);
    in_item_t item;
    item.row_start = field_t'(r0);
    item.col_start = field_t'(c0);
    item.row_end   = field_t'(r1);
    item.col_end   = field_t'(c1);
    return item;
  endfunction

  function automatic in_item_t random_ray();
    return in_item_t'(16'($urandom_range(16'hffff)));
  endfunction

  function automatic out_item_t make_cell(input int r, input int c);
    out_item_t result;
    result.cell_row  = field_t'(r);
    result.cell_col  = field_t'(c);
    result.last_cell = 1'b0;
    return result;
  endfunction

  // Walks the ray and queues every cell strictly between the endpoints.
  task automatic predict_ray_cells(input in_item_t item);
    out_item_t ray_cells[$];
    int r0, c0, r1, c1, dr, dc, sr, sc, adr, adc, r, c, tr, tc;
    r0  = item.row_start;
    c0  = item.col_start;
    r1  = item.row_end;
    c1  = item.col_end;
    dr  = r1 - r0;
    dc  = c1 - c0;
    sr  = (dr > 0) - (dr < 0);
    sc  = (dc > 0) - (dc < 0);
    adr = (dr < 0) ? -dr : dr;
    adc = (dc < 0) ? -dc : dc;
    if (dr == 0 && dc == 0) begin
      return;
    end
    if (adr == 0 || adc == 0) begin
      r = r0 + sr;
      c = c0 + sc;
      while (!(r == r1 && c == c1) && ray_cells.size() < MAX_RAY_CELLS) begin
        ray_cells.push_back(make_cell(r, c));
        r += sr;
        c += sc;
      end
    end else begin
      r  = r0;
      c  = c0;
      tr = adc;
      tc = adr;
      for (int guard = 0; guard < 64; guard++) begin
        if (tr < tc) begin
          r  += sr;
          tr += 2 * adc;
        end else if (tc < tr) begin
          c  += sc;
          tc += 2 * adr;
        end else begin
          // Exact corner crossing: both neighbors, then the diagonal cell.
          if (!(r + sr == r1 && c == c1) && ray_cells.size() < MAX_RAY_CELLS) begin
            ray_cells.push_back(make_cell(r + sr, c));
          end
          if (!(r == r1 && c + sc == c1) && ray_cells.size() < MAX_RAY_CELLS) begin
            ray_cells.push_back(make_cell(r, c + sc));
          end
          r  += sr;
          c  += sc;
          tr += 2 * adc;
          tc += 2 * adr;
        end
        if (r == r1 && c == c1) break;
        if (ray_cells.size() >= MAX_RAY_CELLS) break;
        ray_cells.push_back(make_cell(r, c));
      end
    end
    if (ray_cells.size() > 0) begin
      ray_cells[ray_cells.size() - 1].last_cell = 1'b1;
    end
    foreach (ray_cells[i]) begin
      expected_cells.push_back(ray_cells[i]);
    end
  endtask

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic send_ray(input in_item_t item);
    while (jitter && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_ray_cells(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= hold_sink || (jitter && $urandom_range(99) < 37);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected cell, expected none, actual (%0d,%0d) last %0b",
                 $time, out_data.cell_row, out_data.cell_col, out_data.last_cell);
        failed = 1'b1;
      end else begin
        want = expected_cells.pop_front();
        report_field("cell_row", want.cell_row, out_data.cell_row);
        report_field("cell_col", want.cell_col, out_data.cell_col);
        report_field("last_cell", int'(want.last_cell), int'(out_data.last_cell));
      end
    end
  end

  task automatic test_short_rays();
    send_ray(make_ray(0, 0, 0, 0));
    send_ray(make_ray(-8, 7, -8, 7));
    send_ray(make_ray(3, 3, 3, 4));
    send_ray(make_ray(3, 3, 2, 3));
    send_ray(make_ray(0, 0, 1, 1));
    send_ray(make_ray(-1, -1, -2, 0));
    wait_drained();
  endtask

  task automatic test_axis_rays();
    send_ray(make_ray(-8, 0, 7, 0));
    send_ray(make_ray(7, 5, -8, 5));
    send_ray(make_ray(2, -8, 2, 7));
    send_ray(make_ray(-3, 7, -3, -8));
    wait_drained();
  endtask

  task automatic test_diagonal_rays();
    send_ray(make_ray(-8, -8, 7, 7));
    send_ray(make_ray(7, 7, -8, -8));
    send_ray(make_ray(7, -8, -8, 7));
    send_ray(make_ray(-8, 7, 7, -8));
    wait_drained();
  endtask

  task automatic test_sloped_rays();
    send_ray(make_ray(-8, -8, -7, 7));
    send_ray(make_ray(7, -8, -8, -7));
    send_ray(make_ray(0, 0, 3, 1));
    send_ray(make_ray(0, 0, 2, 4));
    send_ray(make_ray(-5, 2, 4, -1));
    send_ray(make_ray(1, -6, -2, 6));
    wait_drained();
  endtask

  task automatic test_full_rate();
    jitter <= 1'b0;
    for (int i = 0; i < 40; i++) send_ray(random_ray());
    jitter <= 1'b1;
    wait_drained();
  endtask

  task automatic test_random_rays();
    for (int i = 0; i < RANDOM_RAYS - 40; i++) send_ray(random_ray());
    wait_drained();
  endtask

  task automatic test_output_hold();
    fork
      begin
        hold_sink <= 1'b1;
        repeat (300) @(posedge clk);
        hold_sink <= 1'b0;
      end
    join_none
    send_ray(make_ray(-8, -8, 7, 7));
    for (int i = 0; i < 10; i++) send_ray(random_ray());
    wait_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    jitter    = 1'b1;
    hold_sink = 1'b0;
    failed    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_rays();
    test_axis_rays();
    test_diagonal_rays();
    test_sloped_rays();
    test_full_rate();
    test_random_rays();
    test_output_hold();
    repeat (60) @(posedge clk);
    if (failed) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule
